>>> rtl/core/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Types, widths and result codes shared by the sorted insert table.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int DAY_W            = 7;
    localparam int TAG_W            = 16;
    localparam int STATUS_W         = 2;
    localparam int CAPACITY_DEFAULT = 32;

    // input item: day_key | payload_tag, padded to whole bytes
    localparam int IN_DATA_W  = 24;
    // result item: out_day | out_tag, padded to whole bytes
    localparam int OUT_DATA_W = 24;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_STORED = 2'd0;
    localparam status_t ST_FULL   = 2'd1;
    localparam status_t ST_LISTED = 2'd2;
    localparam status_t ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [DAY_W-1:0] day;
    } entry_t;

endpackage

>>> rtl/core/sorted_insert_table.sv
// An insert moves each stored entry, from the tail upwards, down one place while its day
//   is not earlier than the new one, then places the new one and presents the result;
//   a full or empty answer goes straight out. A listing gives each entry once the sink has room.
// One input item at a time: the memory's one read and one write port and the comparator are reused in
// every step, and s_axis_tready is high only between items.
// Reset clears the entry count and control state; the table memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_insert_table
// Table of day-keyed entries held in ascending order, with insert-by-shift
// and an ordered listing that empties the table.
// ----------------------------------------------------------------------------
module sorted_insert_table #(
    parameter int CAPACITY = sit_pkg::CAPACITY_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [sit_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // day_key, payload_tag, pad
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [sit_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // out_day, out_tag, pad
    output logic [sit_pkg::STATUS_W-1:0]   m_axis_tuser,  // status
    output logic                           m_axis_tlast
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PAD_W = sit_pkg::OUT_DATA_W - sit_pkg::DAY_W - sit_pkg::TAG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_LST_RD,
        S_LST_OUT,
        S_RESP
    } state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [IDX_W-1:0]          idx_reg;
    sit_pkg::entry_t           new_reg;
    sit_pkg::status_t          resp_reg;

    logic                      out_valid_reg;
    sit_pkg::status_t          out_status_reg;
    logic [sit_pkg::DAY_W-1:0] out_day_reg;
    logic [sit_pkg::TAG_W-1:0] out_tag_reg;
    logic                      out_last_reg;

    sit_pkg::entry_t           mem [CAPACITY];
    sit_pkg::entry_t           rd_data_reg;
    logic [IDX_W-1:0]          rd_addr;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    sit_pkg::entry_t           mem_wdata;

    logic                      out_free;
    logic                      out_load;
    logic                      in_fire;
    logic [sit_pkg::DAY_W-1:0] in_day;
    logic [sit_pkg::TAG_W-1:0] in_tag;
    logic                      list_last;

    assign in_day   = s_axis_tdata[sit_pkg::DAY_W-1:0];
    assign in_tag   = s_axis_tdata[sit_pkg::DAY_W +: sit_pkg::TAG_W];
    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_load = (state_reg == S_LST_OUT || state_reg == S_RESP) && out_free;
    assign in_fire  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_tag_reg, out_day_reg};

    // insert walks from the tail upwards reading the entry above, listing walks down
    always_comb
    begin
        if (state_reg == S_INS_RD || state_reg == S_INS_CMP)
        begin
            rd_addr = idx_reg - IDX_W'(1);
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    assign list_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // one write a step: either move the entry above down, or drop the new one in
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = new_reg;
        if (state_reg == S_INS_RD && idx_reg == '0)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_INS_CMP)
        begin
            mem_we = 1'b1;
            if (rd_data_reg.day >= new_reg.day)
            begin
                mem_wdata = rd_data_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            new_reg        <= '0;
            resp_reg       <= sit_pkg::ST_STORED;
            out_valid_reg  <= 1'b0;
            out_status_reg <= sit_pkg::ST_STORED;
            out_day_reg    <= '0;
            out_tag_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        new_reg.day <= in_day;
                        new_reg.tag <= in_tag;
                        if (in_day == '0)
                        begin
                            idx_reg <= '0;
                            if (count_reg == '0)
                            begin
                                resp_reg  <= sit_pkg::ST_EMPTY;
                                state_reg <= S_RESP;
                            end
                            else
                            begin
                                state_reg <= S_LST_RD;
                            end
                        end
                        else if (count_reg == CNT_W'(CAPACITY))
                        begin
                            resp_reg  <= sit_pkg::ST_FULL;
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            idx_reg   <= IDX_W'(count_reg);
                            state_reg <= S_INS_RD;
                        end
                    end
                end

                S_INS_RD:
                begin
                    if (idx_reg == '0)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        resp_reg  <= sit_pkg::ST_STORED;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_INS_CMP;
                    end
                end

                S_INS_CMP:
                begin
                    if (rd_data_reg.day >= new_reg.day)
                    begin
                        idx_reg   <= idx_reg - IDX_W'(1);
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        resp_reg  <= sit_pkg::ST_STORED;
                        state_reg <= S_RESP;
                    end
                end

                S_LST_RD:
                begin
                    state_reg <= S_LST_OUT;
                end

                S_LST_OUT:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= sit_pkg::ST_LISTED;
                        out_day_reg    <= rd_data_reg.day;
                        out_tag_reg    <= rd_data_reg.tag;
                        out_last_reg   <= list_last;
                        if (list_last)
                        begin
                            count_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= S_LST_RD;
                        end
                    end
                end

                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= resp_reg;
                        out_day_reg    <= '0;
                        out_tag_reg    <= '0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // the count never runs past the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // a shift step only happens with room left in the table
    a_shift_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS_CMP |-> count_reg < CNT_W'(CAPACITY))
        else $error("shift into a full table");

    // only listed entries come in runs; every other answer closes its item
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != sit_pkg::ST_LISTED |-> out_last_reg)
        else $error("single answer without tlast");

    // a full answer is only ever pending while the table is full
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == sit_pkg::ST_FULL
            |-> count_reg == CNT_W'(CAPACITY))
        else $error("full answer with room in the table");

endmodule
